>>> design/csl_pkg.sv
// Shared types, constants and byte classification for the C-subset lexer.
package csl_pkg;

  localparam int CMD_DEPTH = 4;
  localparam int TOK_DEPTH = 4;

  localparam logic [5:0] KIND_NUM   = 6'd32;
  localparam logic [5:0] KIND_IDENT = 6'd33;
  localparam logic [5:0] KIND_STR   = 6'd34;
  localparam logic [5:0] KIND_END   = 6'd35;
  localparam logic [5:0] KIND_KW0   = 6'd36;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN = 3'd1;
  localparam logic [2:0] ERR_COMMENT = 3'd2;
  localparam logic [2:0] ERR_STRING  = 3'd3;
  localparam logic [2:0] ERR_LONG    = 3'd4;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_OP, MODE_NUM, MODE_IDENT, MODE_STR, MODE_LINE, MODE_BLOCK, MODE_BSTAR
  } scan_mode_t;

  typedef struct packed {
    logic       is_digit;
    logic       is_alpha;
    logic       is_space;
    logic       may_pair;
    logic       is_single;
    logic [5:0] single_kind;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        eoi;
    byte_class_t cls;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [15:0] row;
    logic [15:0] col;
    logic [31:0] off;
    logic [8:0]  len;
    logic [31:0] val;
    logic        last;
  } token_t;

  typedef logic [7:0][7:0] kw_buf_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    c = '0;
    c.is_digit = (b >= 8'h30) && (b <= 8'h39);
    c.is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
                 || (b == CH_UNDER);
    c.is_space = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    c.may_pair = (b == "+") || (b == "-") || (b == "&") || (b == "|") || (b == "=")
                 || (b == "<") || (b == ">") || (b == "!") || (b == "/");
    c.is_single = 1'b1;
    unique case (b)
      "+": c.single_kind = 6'd0;
      "-": c.single_kind = 6'd2;
      "*": c.single_kind = 6'd5;
      "/": c.single_kind = 6'd6;
      "&": c.single_kind = 6'd7;
      "|": c.single_kind = 6'd9;
      "^": c.single_kind = 6'd11;
      "~": c.single_kind = 6'd12;
      "(": c.single_kind = 6'd13;
      ")": c.single_kind = 6'd14;
      "=": c.single_kind = 6'd15;
      ";": c.single_kind = 6'd17;
      ",": c.single_kind = 6'd18;
      ".": c.single_kind = 6'd19;
      "{": c.single_kind = 6'd20;
      "}": c.single_kind = 6'd21;
      "[": c.single_kind = 6'd22;
      "]": c.single_kind = 6'd23;
      "<": c.single_kind = 6'd24;
      ">": c.single_kind = 6'd27;
      "!": c.single_kind = 6'd30;
      default: begin
        c.is_single   = 1'b0;
        c.single_kind = 6'd0;
      end
    endcase
    return c;
  endfunction

  // {hit, kind} for a two-byte operator
  function automatic logic [6:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [6:0] r;
    r = '0;
    if (a == "+" && b == "+") r = {1'b1, 6'd1};
    else if (a == "-" && b == "-") r = {1'b1, 6'd3};
    else if (a == "-" && b == ">") r = {1'b1, 6'd4};
    else if (a == "&" && b == "&") r = {1'b1, 6'd8};
    else if (a == "|" && b == "|") r = {1'b1, 6'd10};
    else if (a == "=" && b == "=") r = {1'b1, 6'd16};
    else if (a == "<" && b == "<") r = {1'b1, 6'd25};
    else if (a == "<" && b == "=") r = {1'b1, 6'd26};
    else if (a == ">" && b == ">") r = {1'b1, 6'd28};
    else if (a == ">" && b == "=") r = {1'b1, 6'd29};
    else if (a == "!" && b == "=") r = {1'b1, 6'd31};
    return r;
  endfunction

  // Keyword text right-aligned, first char in the highest used byte.
  function automatic logic [63:0] kw_text(input logic [3:0] i);
    logic [63:0] t;
    unique case (i)
      4'd0:  t = 64'("sizeof");
      4'd1:  t = 64'("if");
      4'd2:  t = 64'("else");
      4'd3:  t = 64'("while");
      4'd4:  t = 64'("for");
      4'd5:  t = 64'("int");
      4'd6:  t = 64'("char");
      4'd7:  t = 64'("void");
      4'd8:  t = 64'("return");
      4'd9:  t = 64'("enum");
      4'd10: t = 64'("struct");
      4'd11: t = 64'("typedef");
      4'd12: t = 64'("break");
      4'd13: t = 64'("continue");
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] i);
    logic [3:0] l;
    unique case (i)
      4'd0, 4'd8, 4'd10:             l = 4'd6;
      4'd1:                          l = 4'd2;
      4'd2, 4'd6, 4'd7, 4'd9:        l = 4'd4;
      4'd3, 4'd12:                   l = 4'd5;
      4'd4, 4'd5:                    l = 4'd3;
      4'd11:                         l = 4'd7;
      4'd13:                         l = 4'd8;
      default:                       l = 4'd0;
    endcase
    return l;
  endfunction

  // identifier kind: keyword kind on a match of the first len bytes
  function automatic logic [5:0] ident_kind(input kw_buf_t buf_in, input logic [3:0] len);
    logic [5:0]  k;
    logic [63:0] t;
    logic [3:0]  l;
    logic        eq;
    k = KIND_IDENT;
    for (int i = 13; i >= 0; i--) begin
      t  = kw_text(4'(i));
      l  = kw_len(4'(i));
      eq = (l == len);
      for (int j = 0; j < 8; j++) begin
        if (j < int'(l)) begin
          if (buf_in[j] != t[(int'(l) - 1 - j) * 8 +: 8]) eq = 1'b0;
        end
      end
      if (eq) k = KIND_KW0 + 6'(i);
    end
    return k;
  endfunction

endpackage

>>> design/csl_front.sv
// Front end: classifies each accepted byte and queues it for the scanner.
module csl_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [7:0]      char_byte,
  input  logic            end_of_input,
  output logic            full,
  input  logic            cmd_pop,
  output logic            cmd_valid,
  output csl_pkg::cmd_t   cmd
);

  localparam int AW = $clog2(csl_pkg::CMD_DEPTH);

  csl_pkg::cmd_t mem [csl_pkg::CMD_DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [AW:0]   cnt_r;
  logic          wr_en;

  assign full      = (cnt_r == (AW+1)'(csl_pkg::CMD_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign wr_en     = push && !full;
  assign cmd       = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr_r] <= '{ch: char_byte, eoi: end_of_input, cls: csl_pkg::classify(char_byte)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_en) wptr_r <= wptr_r + 1'b1;
      if (cmd_pop) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(cmd_pop);
    end
  end

endmodule

>>> design/csl_scan.sv
// Back end: token scanner state machine, up to two tokens per byte.
module csl_scan #(
  parameter int MAX_TOKEN_LEN = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  csl_pkg::cmd_t    cmd,
  input  logic             out_room,
  output logic             cmd_pop,
  output logic [1:0]       wr_cnt,
  output csl_pkg::token_t  tok0,
  output csl_pkg::token_t  tok1
);

  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_TOKEN_LEN);

  csl_pkg::scan_mode_t mode_r, mode_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [15:0]      row_r, row_nxt, col_r, col_nxt, trow_r, trow_nxt, tcol_r, tcol_nxt;
  logic [31:0]      off_r, off_nxt, toff_r, toff_nxt, acc_r, acc_nxt;
  logic [LW-1:0]    tlen_r, tlen_nxt;
  csl_pkg::kw_buf_t kb_r, kb_nxt;
  logic             halt_r, halt_nxt;

  csl_pkg::token_t  t [2];
  logic [1:0]       n;
  logic             used;
  logic [6:0]       pk;
  logic [7:0]       b;
  csl_pkg::byte_class_t c;
  logic [3:0]       klen;

  assign cmd_pop = cmd_valid && out_room;
  assign b       = cmd.ch;
  assign c       = cmd.cls;
  assign klen    = (tlen_r <= LW'(8)) ? 4'(tlen_r) : 4'd15;

  function automatic csl_pkg::token_t mk(input logic [5:0] k, input logic [2:0] e,
      input logic [15:0] r, input logic [15:0] cl, input logic [31:0] o,
      input logic [8:0] l, input logic [31:0] v);
    csl_pkg::token_t x;
    x = '{kind: k, err: e, row: r, col: cl, off: o, len: l, val: v, last: 1'b0};
    return x;
  endfunction

  always_comb begin
    mode_nxt = mode_r; pend_nxt = pend_r; row_nxt = row_r; col_nxt = col_r;
    off_nxt = off_r; trow_nxt = trow_r; tcol_nxt = tcol_r; toff_nxt = toff_r;
    tlen_nxt = tlen_r; acc_nxt = acc_r; kb_nxt = kb_r; halt_nxt = halt_r;
    t[0] = '0; t[1] = '0; n = 2'd0; used = 1'b1;
    pk = csl_pkg::pair_kind(pend_r, b);
    if (cmd_pop && !halt_r) begin
      if (cmd.eoi) begin
        unique case (mode_r)
          csl_pkg::MODE_OP: begin
            t[n[0]] = mk(csl_pkg::classify(pend_r).single_kind, csl_pkg::ERR_NONE,
                         trow_r, tcol_r, toff_r, 9'd1, '0);
            n = n + 2'd1;
          end
          csl_pkg::MODE_NUM: begin
            t[n[0]] = mk(csl_pkg::KIND_NUM, csl_pkg::ERR_NONE, trow_r, tcol_r, toff_r,
                         9'(tlen_r), acc_r);
            n = n + 2'd1;
          end
          csl_pkg::MODE_IDENT: begin
            t[n[0]] = mk(csl_pkg::ident_kind(kb_r, klen), csl_pkg::ERR_NONE, trow_r,
                         tcol_r, toff_r, 9'(tlen_r), '0);
            n = n + 2'd1;
          end
          csl_pkg::MODE_STR: begin
            t[n[0]] = mk('0, csl_pkg::ERR_STRING, trow_r, tcol_r, toff_r, '0, '0);
            n = n + 2'd1;
            halt_nxt = 1'b1;
          end
          csl_pkg::MODE_BLOCK, csl_pkg::MODE_BSTAR: begin
            t[n[0]] = mk('0, csl_pkg::ERR_COMMENT, trow_r, tcol_r, toff_r, '0, '0);
            n = n + 2'd1;
            halt_nxt = 1'b1;
          end
          default: ;
        endcase
        if (!halt_nxt) begin
          t[n[0]] = mk(csl_pkg::KIND_END, csl_pkg::ERR_NONE, row_r, col_r, off_r, '0, '0);
          n = n + 2'd1;
        end
        halt_nxt = 1'b1;
        mode_nxt = csl_pkg::MODE_IDLE;
      end else begin
        unique case (mode_r)
          csl_pkg::MODE_OP: begin
            if (pend_r == csl_pkg::CH_SLASH && b == csl_pkg::CH_SLASH) begin
              mode_nxt = csl_pkg::MODE_LINE;
            end else if (pend_r == csl_pkg::CH_SLASH && b == csl_pkg::CH_STAR) begin
              mode_nxt = csl_pkg::MODE_BLOCK;
            end else if (pk[6]) begin
              t[n[0]] = mk(pk[5:0], csl_pkg::ERR_NONE, trow_r, tcol_r, toff_r, 9'd2, '0);
              n = n + 2'd1;
              mode_nxt = csl_pkg::MODE_IDLE;
            end else begin
              t[n[0]] = mk(csl_pkg::classify(pend_r).single_kind, csl_pkg::ERR_NONE,
                           trow_r, tcol_r, toff_r, 9'd1, '0);
              n = n + 2'd1;
              mode_nxt = csl_pkg::MODE_IDLE;
              used = 1'b0;
            end
          end
          csl_pkg::MODE_NUM: begin
            if (!c.is_digit) begin
              t[n[0]] = mk(csl_pkg::KIND_NUM, csl_pkg::ERR_NONE, trow_r, tcol_r, toff_r,
                           9'(tlen_r), acc_r);
              n = n + 2'd1;
              mode_nxt = csl_pkg::MODE_IDLE;
              used = 1'b0;
            end else if (tlen_r >= MAX_LEN) begin
              t[n[0]] = mk('0, csl_pkg::ERR_LONG, trow_r, tcol_r, toff_r, '0, '0);
              n = n + 2'd1;
              halt_nxt = 1'b1;
            end else begin
              tlen_nxt = tlen_r + 1'b1;
              acc_nxt  = (acc_r << 3) + (acc_r << 1) + 32'(b[3:0]);
            end
          end
          csl_pkg::MODE_IDENT: begin
            if (!(c.is_alpha || c.is_digit)) begin
              t[n[0]] = mk(csl_pkg::ident_kind(kb_r, klen), csl_pkg::ERR_NONE, trow_r,
                           tcol_r, toff_r, 9'(tlen_r), '0);
              n = n + 2'd1;
              mode_nxt = csl_pkg::MODE_IDLE;
              used = 1'b0;
            end else if (tlen_r >= MAX_LEN) begin
              t[n[0]] = mk('0, csl_pkg::ERR_LONG, trow_r, tcol_r, toff_r, '0, '0);
              n = n + 2'd1;
              halt_nxt = 1'b1;
            end else begin
              if (tlen_r < LW'(8)) kb_nxt[tlen_r[2:0]] = b;
              tlen_nxt = tlen_r + 1'b1;
            end
          end
          csl_pkg::MODE_STR: begin
            if (tlen_r >= MAX_LEN) begin
              t[n[0]] = mk('0, csl_pkg::ERR_LONG, trow_r, tcol_r, toff_r, '0, '0);
              n = n + 2'd1;
              halt_nxt = 1'b1;
            end else begin
              tlen_nxt = tlen_r + 1'b1;
              if (b == csl_pkg::CH_QUOTE) begin
                t[n[0]] = mk(csl_pkg::KIND_STR, csl_pkg::ERR_NONE, trow_r, tcol_r, toff_r,
                             9'(tlen_nxt), '0);
                n = n + 2'd1;
                mode_nxt = csl_pkg::MODE_IDLE;
              end
            end
          end
          csl_pkg::MODE_LINE: begin
            if (b == csl_pkg::CH_NL) mode_nxt = csl_pkg::MODE_IDLE;
          end
          csl_pkg::MODE_BLOCK: begin
            if (b == csl_pkg::CH_STAR) mode_nxt = csl_pkg::MODE_BSTAR;
          end
          csl_pkg::MODE_BSTAR: begin
            if (b == csl_pkg::CH_SLASH) mode_nxt = csl_pkg::MODE_IDLE;
            else if (b != csl_pkg::CH_STAR) mode_nxt = csl_pkg::MODE_BLOCK;
          end
          default: begin
            mode_nxt = csl_pkg::MODE_IDLE;
            used = 1'b0;
          end
        endcase

        // byte starts a new token
        if (!halt_nxt && !used) begin
          trow_nxt = row_r; tcol_nxt = col_r; toff_nxt = off_r;
          tlen_nxt = LW'(1); acc_nxt = '0;
          priority if (c.is_space) begin
            tlen_nxt = '0;
          end else if (c.may_pair) begin
            pend_nxt = b;
            mode_nxt = csl_pkg::MODE_OP;
          end else if (c.is_single) begin
            t[n[0]] = mk(c.single_kind, csl_pkg::ERR_NONE, row_r, col_r, off_r, 9'd1, '0);
            n = n + 2'd1;
          end else if (c.is_digit) begin
            acc_nxt  = 32'(b[3:0]);
            mode_nxt = csl_pkg::MODE_NUM;
          end else if (c.is_alpha) begin
            kb_nxt[0] = b;
            mode_nxt  = csl_pkg::MODE_IDENT;
          end else if (b == csl_pkg::CH_QUOTE) begin
            mode_nxt = csl_pkg::MODE_STR;
          end else begin
            t[n[0]] = mk('0, csl_pkg::ERR_UNKNOWN, row_r, col_r, off_r, '0, '0);
            n = n + 2'd1;
            halt_nxt = 1'b1;
          end
        end

        if (b == csl_pkg::CH_NL) begin
          if (row_r != 16'hFFFF) row_nxt = row_r + 1'b1;
          col_nxt = 16'd1;
        end else if (col_r != 16'hFFFF) begin
          col_nxt = col_r + 1'b1;
        end
        off_nxt = off_r + 1'b1;
      end
    end
    if (n == 2'd1) t[0].last = 1'b1;
    if (n == 2'd2) t[1].last = 1'b1;
  end

  assign wr_cnt = n;
  assign tok0   = t[0];
  assign tok1   = t[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= csl_pkg::MODE_IDLE;
      pend_r <= '0;
      row_r  <= 16'd1;
      col_r  <= 16'd1;
      off_r  <= '0;
      trow_r <= 16'd1;
      tcol_r <= 16'd1;
      toff_r <= '0;
      tlen_r <= '0;
      acc_r  <= '0;
      kb_r   <= '0;
      halt_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      off_r  <= off_nxt;
      trow_r <= trow_nxt;
      tcol_r <= tcol_nxt;
      toff_r <= toff_nxt;
      tlen_r <= tlen_nxt;
      acc_r  <= acc_nxt;
      kb_r   <= kb_nxt;
      halt_r <= halt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("halt released without reset");
  a_no_out_halted: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> (wr_cnt == 2'd0)) else $error("token after halt");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tlen_r <= MAX_LEN) else $error("token length past limit");
  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_cnt != 2'd0) |-> (cmd_pop && out_room)) else $error("write without room");
`endif

endmodule

>>> design/csl_tok_fifo.sv
// Result queue: takes up to two tokens per cycle, hands out one.
module csl_tok_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       wr_cnt,
  input  csl_pkg::token_t  tok0,
  input  csl_pkg::token_t  tok1,
  output logic             room,
  output logic             empty,
  input  logic             pop,
  output csl_pkg::token_t  head
);

  localparam int AW = $clog2(csl_pkg::TOK_DEPTH);

  csl_pkg::token_t mem [csl_pkg::TOK_DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [AW:0]   cnt_r;
  logic          rd_en;

  assign empty = (cnt_r == '0);
  assign room  = (cnt_r <= (AW+1)'(csl_pkg::TOK_DEPTH - 2));
  assign rd_en = pop && !empty;
  assign head  = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) mem[wptr_r] <= tok0;
    if (wr_cnt == 2'd2) mem[wptr_r + 1'b1] <= tok1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + AW'(wr_cnt);
      if (rd_en) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_cnt) - (AW+1)'(rd_en);
    end
  end

endmodule

>>> design/c_subset_lexer.sv
// Top level of the streaming C-subset lexer.
// One source byte (or an end-of-input mark) is taken per word through push/full, and tokens
// come out through empty/pop, oldest first; a byte may give zero, one or two tokens, the last
// of them flagged by out_last_of_run. The scanner takes one queued byte per clock, so the
// block sustains one byte per cycle as long as results are drained; it pauses a byte only
// while the four-entry result queue has fewer than two free slots. A word is queued in the
// front queue, and its tokens in the result queue, before they reach the result ports. After
// an error or the end token the block drops further input without results until reset.
module c_subset_lexer #(
  parameter int MAX_TOKEN_LEN = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  out_token_kind,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_start_row,
  output logic [15:0] out_start_col,
  output logic [31:0] out_start_offset,
  output logic [8:0]  out_token_length,
  output logic [31:0] out_number_value,
  output logic        out_last_of_run
);

  logic            cmd_pop, cmd_valid, room;
  csl_pkg::cmd_t   cmd;
  logic [1:0]      wr_cnt;
  csl_pkg::token_t tok0, tok1, head;

  csl_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .char_byte(in_char_byte),
    .end_of_input(in_end_of_input), .full(full), .cmd_pop(cmd_pop),
    .cmd_valid(cmd_valid), .cmd(cmd)
  );

  csl_scan #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_scan (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .out_room(room),
    .cmd_pop(cmd_pop), .wr_cnt(wr_cnt), .tok0(tok0), .tok1(tok1)
  );

  csl_tok_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_cnt(wr_cnt), .tok0(tok0), .tok1(tok1),
    .room(room), .empty(empty), .pop(pop), .head(head)
  );

  assign out_token_kind   = head.kind;
  assign out_error_code   = head.err;
  assign out_start_row    = head.row;
  assign out_start_col    = head.col;
  assign out_start_offset = head.off;
  assign out_token_length = head.len;
  assign out_number_value = head.val;
  assign out_last_of_run  = head.last;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the streaming C-subset lexer.
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_LEN   = 256;
  localparam int IDLE_LIM  = 3000;
  localparam int N_ITEMS   = 550;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_char_byte;
  logic        in_end_of_input;
  logic        empty;
  logic        pop;
  logic [5:0]  out_token_kind;
  logic [2:0]  out_error_code;
  logic [15:0] out_start_row;
  logic [15:0] out_start_col;
  logic [31:0] out_start_offset;
  logic [8:0]  out_token_length;
  logic [31:0] out_number_value;
  logic        out_last_of_run;

  c_subset_lexer dut (.*);

  // Predicts the tokens of each accepted word and checks them in order.
  class lexer_scoreboard;
    csl_pkg::scan_mode_t mode;
    bit [7:0]    pend;
    bit [15:0]   row, col, trow, tcol;
    bit [31:0]   off, toff, acc;
    int          tlen;
    bit [7:0]    kwb[8];
    bit          halted;
    csl_pkg::token_t expq[$];
    int          errors;
    string       kw_names[14] = '{"sizeof", "if", "else", "while", "for", "int", "char",
                                  "void", "return", "enum", "struct", "typedef", "break",
                                  "continue"};

    function new();
      mode = csl_pkg::MODE_IDLE; pend = 0; row = 1; col = 1; off = 0;
      trow = 1; tcol = 1; toff = 0; tlen = 0; acc = 0; halted = 0; errors = 0;
      foreach (kwb[i]) kwb[i] = 0;
    endfunction

    function bit is_digit(bit [7:0] b);
      return b >= "0" && b <= "9";
    endfunction
    function bit is_alpha(bit [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == csl_pkg::CH_UNDER;
    endfunction
    function bit is_space(bit [7:0] b);
      return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction
    function bit pairable(bit [7:0] b);
      return b == "+" || b == "-" || b == "&" || b == "|" || b == "=" || b == "<" ||
             b == ">" || b == "!" || b == "/";
    endfunction

    // punctuator kind of a lone byte, -1 if none
    function int lone_kind(bit [7:0] b);
      case (b)
        "+": return 0;  "-": return 2;  "*": return 5;  "/": return 6;
        "&": return 7;  "|": return 9;  "^": return 11; "~": return 12;
        "(": return 13; ")": return 14; "=": return 15; ";": return 17;
        ",": return 18; ".": return 19; "{": return 20; "}": return 21;
        "[": return 22; "]": return 23; "<": return 24; ">": return 27;
        "!": return 30;
        default: return -1;
      endcase
    endfunction

    function int twin_kind(bit [7:0] a, bit [7:0] b);
      case ({a, b})
        "++": return 1;  "--": return 3;  "->": return 4;  "&&": return 8;
        "||": return 10; "==": return 16; "<<": return 25; "<=": return 26;
        ">>": return 28; ">=": return 29; "!=": return 31;
        default: return -1;
      endcase
    endfunction

    function void add(bit [5:0] kind, bit [2:0] err, bit [15:0] r, bit [15:0] c,
                      bit [31:0] o, bit [8:0] len, bit [31:0] val);
      csl_pkg::token_t t;
      t = '0;
      t.kind = kind; t.err = err; t.row = r; t.col = c; t.off = o; t.len = len; t.val = val;
      expq.push_back(t);
    endfunction

    function void add_tok(bit [5:0] kind, bit [8:0] len, bit [31:0] val);
      add(kind, csl_pkg::ERR_NONE, trow, tcol, toff, len, val);
    endfunction

    function void add_err(bit [2:0] err, bit [15:0] r, bit [15:0] c, bit [31:0] o);
      add(6'd0, err, r, c, o, 9'd0, 32'd0);
      halted = 1;
    endfunction

    function void flush_ident();
      bit [5:0] kind;
      bit       hit;
      kind = csl_pkg::KIND_IDENT;
      if (tlen <= 8) begin
        for (int i = 0; i < 14; i++) begin
          hit = (kw_names[i].len() == tlen);
          for (int j = 0; j < tlen && hit; j++)
            if (kw_names[i][j] != kwb[j]) hit = 0;
          if (hit && kind == csl_pkg::KIND_IDENT) kind = csl_pkg::KIND_KW0 + 6'(i);
        end
      end
      add_tok(kind, 9'(tlen), 32'd0);
    endfunction

    function void note(bit [7:0] b, bit eoi);
      int  n0;
      bit  used;
      int  k;
      n0 = expq.size();
      used = 1;
      if (halted) return;
      if (eoi) begin
        case (mode)
          csl_pkg::MODE_OP:    add_tok(6'(lone_kind(pend)), 9'd1, 32'd0);
          csl_pkg::MODE_NUM:   add_tok(csl_pkg::KIND_NUM, 9'(tlen), acc);
          csl_pkg::MODE_IDENT: flush_ident();
          csl_pkg::MODE_STR:   add_err(csl_pkg::ERR_STRING, trow, tcol, toff);
          csl_pkg::MODE_BLOCK, csl_pkg::MODE_BSTAR:
            add_err(csl_pkg::ERR_COMMENT, trow, tcol, toff);
          default: ;
        endcase
        if (!halted) add(csl_pkg::KIND_END, csl_pkg::ERR_NONE, row, col, off, 9'd0, 32'd0);
        halted = 1;
        mode = csl_pkg::MODE_IDLE;
      end else begin
        case (mode)
          csl_pkg::MODE_OP: begin
            k = twin_kind(pend, b);
            if (pend == csl_pkg::CH_SLASH && b == csl_pkg::CH_SLASH)
              mode = csl_pkg::MODE_LINE;
            else if (pend == csl_pkg::CH_SLASH && b == csl_pkg::CH_STAR)
              mode = csl_pkg::MODE_BLOCK;
            else if (k >= 0) begin
              add_tok(6'(k), 9'd2, 32'd0); mode = csl_pkg::MODE_IDLE;
            end else begin
              add_tok(6'(lone_kind(pend)), 9'd1, 32'd0); mode = csl_pkg::MODE_IDLE; used = 0;
            end
          end
          csl_pkg::MODE_NUM: begin
            if (!is_digit(b)) begin
              add_tok(csl_pkg::KIND_NUM, 9'(tlen), acc); mode = csl_pkg::MODE_IDLE; used = 0;
            end else if (tlen >= MAX_LEN) add_err(csl_pkg::ERR_LONG, trow, tcol, toff);
            else begin
              tlen++; acc = acc * 10 + 32'(b - "0");
            end
          end
          csl_pkg::MODE_IDENT: begin
            if (!(is_alpha(b) || is_digit(b))) begin
              flush_ident(); mode = csl_pkg::MODE_IDLE; used = 0;
            end else if (tlen >= MAX_LEN) add_err(csl_pkg::ERR_LONG, trow, tcol, toff);
            else begin
              if (tlen < 8) kwb[tlen] = b;
              tlen++;
            end
          end
          csl_pkg::MODE_STR: begin
            if (tlen >= MAX_LEN) add_err(csl_pkg::ERR_LONG, trow, tcol, toff);
            else begin
              tlen++;
              if (b == csl_pkg::CH_QUOTE) begin
                add_tok(csl_pkg::KIND_STR, 9'(tlen), 32'd0); mode = csl_pkg::MODE_IDLE;
              end
            end
          end
          csl_pkg::MODE_LINE:  if (b == csl_pkg::CH_NL) mode = csl_pkg::MODE_IDLE;
          csl_pkg::MODE_BLOCK: if (b == csl_pkg::CH_STAR) mode = csl_pkg::MODE_BSTAR;
          csl_pkg::MODE_BSTAR: begin
            if (b == csl_pkg::CH_SLASH) mode = csl_pkg::MODE_IDLE;
            else if (b != csl_pkg::CH_STAR) mode = csl_pkg::MODE_BLOCK;
          end
          default: begin
            mode = csl_pkg::MODE_IDLE; used = 0;
          end
        endcase
        if (!halted && !used) begin
          trow = row; tcol = col; toff = off; tlen = 1; acc = 0;
          if (is_space(b)) tlen = 0;
          else if (pairable(b)) begin
            pend = b; mode = csl_pkg::MODE_OP;
          end else if (lone_kind(b) >= 0) add_tok(6'(lone_kind(b)), 9'd1, 32'd0);
          else if (is_digit(b)) begin
            acc = 32'(b - "0"); mode = csl_pkg::MODE_NUM;
          end else if (is_alpha(b)) begin
            kwb[0] = b; mode = csl_pkg::MODE_IDENT;
          end else if (b == csl_pkg::CH_QUOTE) mode = csl_pkg::MODE_STR;
          else add_err(csl_pkg::ERR_UNKNOWN, row, col, off);
        end
        if (b == csl_pkg::CH_NL) begin
          if (row != 16'hFFFF) row++;
          col = 1;
        end else if (col != 16'hFFFF) col++;
        off++;
      end
      if (expq.size() > n0) expq[$].last = 1;
    endfunction

    function void check(csl_pkg::token_t got);
      csl_pkg::token_t want;
      if (expq.size() == 0) begin
        $display("%0t: unexpected word kind %0d err %0d", $time, got.kind, got.err);
        errors++;
        return;
      end
      want = expq.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch (kind err row col off len val last)", $time);
        $display("%0t:   expected %0d %0d %0d %0d %0d %0d %0d %0d", $time, want.kind,
                 want.err, want.row, want.col, want.off, want.len, want.val, want.last);
        $display("%0t:   actual   %0d %0d %0d %0d %0d %0d %0d %0d", $time, got.kind,
                 got.err, got.row, got.col, got.off, got.len, got.val, got.last);
        errors++;
      end
    endfunction
  endclass

  lexer_scoreboard sb = new();
  bit [7:0] src[$];
  int       n_in;
  int       idle_cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // sampling at the edge sees the values the block saw
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        sb.note(in_char_byte, in_end_of_input);
        n_in++;
      end
      if (pop && !empty)
        sb.check({out_token_kind, out_error_code, out_start_row, out_start_col,
                  out_start_offset, out_token_length, out_number_value, out_last_of_run});
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIM) begin
        $display("%0t: no progress", $time);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // receiver: random short stalls, rare long ones, and one long hold-off to fill the block
  initial begin : drain
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!held && n_in >= 120) begin
        held = 1;
        hold_left = 400;
        pop <= 1'b0;
      end else if ($urandom_range(0, 199) == 0) begin
        hold_left = $urandom_range(10, 40);
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) < 75);
      end
    end
  end

  task automatic send_word(bit [7:0] b, bit eoi);
    int r;
    push <= 1'b1;
    in_char_byte <= b;
    in_end_of_input <= eoi;
    do @(posedge clk); while (full);
    r = $urandom_range(0, 99);
    if (r >= 60) begin
      push <= 1'b0;
      in_char_byte <= 8'($urandom);
      if (r < 95) repeat ($urandom_range(1, 3)) @(posedge clk);
      else repeat ($urandom_range(10, 30)) @(posedge clk);
    end
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) src.push_back(s[i]);
  endtask

  task automatic flush_src();
    while (src.size() > 0) send_word(src.pop_front(), 1'b0);
  endtask

  // one well-formed lexeme with random content (or none), then at most one whitespace byte
  task automatic add_lexeme();
    string letters, digits, kws[14], ops[32], blanks;
    int    sel, len;
    bit [7:0] c;
    letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    digits  = "0123456789";
    blanks  = " \t\n\r\v\f";
    kws = '{"sizeof", "if", "else", "while", "for", "int", "char", "void", "return", "enum",
            "struct", "typedef", "break", "continue"};
    ops = '{"+", "++", "-", "--", "->", "*", "&", "&&", "|", "||", "^", "~", "(", ")", "=",
            "==", ";", ",", ".", "{", "}", "[", "]", "<", "<<", "<=", ">", ">>", ">=", "!",
            "!=", "/"};
    sel = $urandom_range(0, 9);
    case (sel)
      0: add_text(kws[$urandom_range(0, 13)]);
      1: begin
        len = $urandom_range(1, 10);
        src.push_back(letters[$urandom_range(0, letters.len() - 1)]);
        for (int i = 1; i < len; i++)
          src.push_back($urandom_range(0, 3) == 0 ? digits[$urandom_range(0, 9)]
                                                  : letters[$urandom_range(0, 52)]);
      end
      2: begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
        for (int i = 0; i < len; i++) src.push_back(digits[$urandom_range(0, 9)]);
      end
      3: begin
        src.push_back(csl_pkg::CH_QUOTE);
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
          do c = 8'($urandom); while (c == csl_pkg::CH_QUOTE);
          src.push_back(c);
        end
        src.push_back(csl_pkg::CH_QUOTE);
      end
      4: begin
        add_text("//");
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
          do c = 8'($urandom); while (c == csl_pkg::CH_NL);
          src.push_back(c);
        end
        src.push_back(csl_pkg::CH_NL);
      end
      5: begin
        add_text("/*");
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++)
          src.push_back($urandom_range(0, 2) == 0 ? csl_pkg::CH_STAR
                                                  : letters[$urandom_range(0, 52)]);
        add_text("*/");
      end
      6, 7: add_text(ops[$urandom_range(0, 31)]);
      default: ;
    endcase
    len = (sel >= 6) ? 1 : $urandom_range(0, 1);
    for (int i = 0; i < len; i++) src.push_back(blanks[$urandom_range(0, 5)]);
  endtask

  initial begin : stim
    int       ending;
    n_in = 0;
    idle_cycles = 0;
    rst_n <= 1'b0;
    push <= 1'b0;
    in_char_byte <= 8'd0;
    in_end_of_input <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: keywords, pairs, arrow, comments, string, number
    add_text("while(_z<=42)x->y++;/**/\"a\"//q\n");
    flush_src();

    while (n_in < N_ITEMS) begin
      add_lexeme();
      flush_src();
    end

    // the stream can end only once per reset; pick how
    ending = $urandom_range(0, 6);
    case (ending)
      0: begin
        add_text("abc");
        src.push_back(8'h80 | 8'($urandom));
      end
      1: add_text("4294967299");
      2: add_text("//abc");
      3: add_text("\"abc");
      4: add_text("/*ab*");
      5: for (int i = 0; i < MAX_LEN + 1; i++) src.push_back("7");
      default: add_text("<");
    endcase
    flush_src();
    if (ending != 0 && ending != 5) send_word(8'd0, 1'b1);
    // after halt these are dropped, but they exercise the top byte bit and the end mark
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    push <= 1'b0;

    while (sb.expq.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
design/csl_pkg.sv
design/csl_front.sv
design/csl_scan.sv
design/csl_tok_fifo.sv
design/c_subset_lexer.sv
tb/sv/testbench.sv
